/* design/rtca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rtca_pkg;

	// Field widths of one item.
	localparam int SEC_W  = 6;
	localparam int HOUR_W = 5;
	localparam int DAY_W  = 9;
	localparam int CTRL_W = 8;
	localparam int EL_W   = 32;

	// Seconds of the clamped clock fit in 26 bits; adding a 32-bit gap needs 33.
	localparam int BASE_W = 26;
	localparam int TIME_W = 33;

	// Widths of the successive quotients: total minutes, total hours, total days.
	localparam int MINS_W = 28;
	localparam int HRS_W  = 23;
	localparam int DAYS_W = 19;

	// Clamp limits of the clock fields.
	localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;
	localparam logic [SEC_W-1:0]  MIN_MAX  = 6'd59;
	localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;

	// Scale factors of the clock fields.
	localparam logic [BASE_W-1:0] SEC_PER_MIN  = 26'd60;
	localparam logic [BASE_W-1:0] SEC_PER_HOUR = 26'd3600;
	localparam logic [BASE_W-1:0] SEC_PER_DAY  = 26'd86400;

	// Reciprocals: n / 15 = (n * RECIP15) >> 35 and n / 3 = (n * RECIP3) >> 33
	// for every 32-bit n.
	localparam logic [31:0] RECIP15 = 32'h8888_8889;
	localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;
	localparam int RECIP15_SH = 35;
	localparam int RECIP3_SH  = 33;

	// Control byte bit positions.
	localparam int CTRL_CARRY_BIT = 7;
	localparam int CTRL_HALT_BIT  = 6;

	// What travels beside the arithmetic: the clamped clock and the control bits.
	typedef struct packed {
		logic              halt;
		logic              carry;
		logic [SEC_W-1:0]  sec;
		logic [SEC_W-1:0]  min;
		logic [HOUR_W-1:0] hour;
		logic [DAY_W-1:0]  day;
	} rtca_side_t;

	// One finished result.
	typedef struct packed {
		logic [SEC_W-1:0]  sec;
		logic [SEC_W-1:0]  min;
		logic [HOUR_W-1:0] hour;
		logic [DAY_W-1:0]  day;
		logic [CTRL_W-1:0] ctrl;
	} rtca_res_t;

endpackage

`default_nettype wire

/* design/rtca_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Request channel: the current clock and the elapsed seconds.
interface rtca_in_if;
	logic        valid;
	logic        ready;
	logic [5:0]  sec_in;
	logic [5:0]  min_in;
	logic [4:0]  hour_in;
	logic [8:0]  day_in;
	logic [7:0]  ctrl_in;
	logic [31:0] elapsed;

	modport source (output valid, sec_in, min_in, hour_in, day_in, ctrl_in, elapsed,
		input ready);
	modport sink (input valid, sec_in, min_in, hour_in, day_in, ctrl_in, elapsed,
		output ready);
endinterface

// Result channel: the advanced clock.
interface rtca_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] sec_out;
	logic [5:0] min_out;
	logic [4:0] hour_out;
	logic [8:0] day_out;
	logic [7:0] ctrl_out;

	modport source (output valid, sec_out, min_out, hour_out, day_out, ctrl_out,
		input ready);
	modport sink (input valid, sec_out, min_out, hour_out, day_out, ctrl_out,
		output ready);
	modport monitor (input valid, ready, sec_out, min_out, hour_out, day_out, ctrl_out);
endinterface

`default_nettype wire

/* design/rtca_front.sv */
`timescale 1ns / 1ps
`default_nettype none

// Stages 1 and 2: clamp the fields, fold them into seconds, add the gap.
module rtca_front import rtca_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	rtca_in_if.sink                req,
	output logic                   t_valid,
	input  wire logic              t_ready,
	output logic [TIME_W-1:0]      t_sum,
	output rtca_side_t             t_side
);

	logic              v_s1, v_s2;
	logic              en_s1, en_s2;
	logic [SEC_W-1:0]  sec_c, min_c;
	logic [HOUR_W-1:0] hour_c;
	logic [BASE_W-1:0] base_s1;
	logic [EL_W-1:0]   el_s1;
	rtca_side_t        side_s1, side_s2;
	logic [TIME_W-1:0] t_s2;

	// A stage loads when it is empty or its contents move on.
	assign en_s2     = !v_s2 || t_ready;
	assign en_s1     = !v_s1 || en_s2;
	assign req.ready = en_s1;

	// Clamp out-of-range seconds, minutes and hours.
	always_comb begin
		sec_c  = (req.sec_in > SEC_MAX) ? SEC_MAX : req.sec_in;
		min_c  = (req.min_in > MIN_MAX) ? MIN_MAX : req.min_in;
		hour_c = (req.hour_in > HOUR_MAX) ? HOUR_MAX : req.hour_in;
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req.valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	// Stage 1: the clamped clock as seconds since day zero.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			base_s1 <= BASE_W'(sec_c) + BASE_W'(min_c) * SEC_PER_MIN
				+ BASE_W'(hour_c) * SEC_PER_HOUR + BASE_W'(req.day_in) * SEC_PER_DAY;
			el_s1         <= req.elapsed;
			side_s1.halt  <= req.ctrl_in[CTRL_HALT_BIT];
			side_s1.carry <= req.ctrl_in[CTRL_CARRY_BIT];
			side_s1.sec   <= sec_c;
			side_s1.min   <= min_c;
			side_s1.hour  <= hour_c;
			side_s1.day   <= req.day_in;
		end
	end

	// Stage 2: add the elapsed seconds.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			t_s2    <= TIME_W'(base_s1) + TIME_W'(el_s1);
			side_s2 <= side_s1;
		end
	end

	assign t_valid = v_s2;
	assign t_sum   = t_s2;
	assign t_side  = side_s2;

endmodule

`default_nettype wire

/* design/rtca_split.sv */
`timescale 1ns / 1ps
`default_nettype none

// Stages 3 to 6: split the total seconds into fields by reciprocal multiplies.
module rtca_split import rtca_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              t_valid,
	output logic                   t_ready,
	input  wire logic [TIME_W-1:0] t_sum,
	input  wire rtca_side_t        t_side,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output rtca_res_t              res
);

	localparam int P1_W = (TIME_W - 2) + 32;
	localparam int P2_W = (MINS_W - 2) + 32;
	localparam int P3_W = (HRS_W - 3) + 32;

	logic              v_s3, v_s4, v_s5, v_s6;
	logic              en_s3, en_s4, en_s5, en_s6;
	rtca_side_t        side_s3, side_s4, side_s5;
	logic [P1_W-1:0]   prod1_s3;
	logic [SEC_W-1:0]  tlo_s3;
	logic [P2_W-1:0]   prod2_s4;
	logic [SEC_W-1:0]  sec_s4, sec_s5;
	logic [SEC_W-1:0]  qmlo_s4;
	logic [P3_W-1:0]   prod3_s5;
	logic [SEC_W-1:0]  min_s5;
	logic [HOUR_W-1:0] qhlo_s5;
	logic [MINS_W-1:0] q_min;
	logic [HRS_W-1:0]  q_hrs;
	logic [DAYS_W-1:0] q_days;
	logic [HOUR_W-1:0] hour_n;
	logic              ovf;
	rtca_res_t         res_s6;

	// Bubble-collapsing stall chain.
	assign en_s6   = !v_s6 || res_ready;
	assign en_s5   = !v_s5 || en_s6;
	assign en_s4   = !v_s4 || en_s5;
	assign en_s3   = !v_s3 || en_s4;
	assign t_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= t_valid;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 3: total / 60 as (total / 4) / 15.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod1_s3 <= P1_W'(t_sum[TIME_W-1:2]) * P1_W'(RECIP15);
			tlo_s3   <= t_sum[SEC_W-1:0];
			side_s3  <= t_side;
		end
	end

	// Stage 4: seconds as the remainder, then minutes / 60.
	assign q_min = prod1_s3[RECIP15_SH +: MINS_W];

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sec_s4   <= tlo_s3 - SEC_W'(q_min[SEC_W-1:0] * 6'd60);
			qmlo_s4  <= q_min[SEC_W-1:0];
			prod2_s4 <= P2_W'(q_min[MINS_W-1:2]) * P2_W'(RECIP15);
			side_s4  <= side_s3;
		end
	end

	// Stage 5: minutes as the remainder, then hours / 24 as (hours / 8) / 3.
	assign q_hrs = prod2_s4[RECIP15_SH +: HRS_W];

	always_ff @(posedge clk) begin
		if (en_s5) begin
			min_s5   <= qmlo_s4 - SEC_W'(q_hrs[SEC_W-1:0] * 6'd60);
			qhlo_s5  <= q_hrs[HOUR_W-1:0];
			prod3_s5 <= P3_W'(q_hrs[HRS_W-1:3]) * P3_W'(RECIP3);
			sec_s5   <= sec_s4;
			side_s5  <= side_s4;
		end
	end

	// Stage 6: hours as the remainder, day wrap and carry, halt selection.
	assign q_days = prod3_s5[RECIP3_SH +: DAYS_W];
	assign hour_n = qhlo_s5 - HOUR_W'(q_days[HOUR_W-1:0] * 5'd24);
	assign ovf    = |q_days[DAYS_W-1:DAY_W];

	always_ff @(posedge clk) begin
		if (en_s6) begin
			if (side_s5.halt) begin
				res_s6.sec  <= side_s5.sec;
				res_s6.min  <= side_s5.min;
				res_s6.hour <= side_s5.hour;
				res_s6.day  <= side_s5.day;
				res_s6.ctrl <= {side_s5.carry, 1'b1, 5'b0, side_s5.day[DAY_W-1]};
			end else begin
				res_s6.sec  <= sec_s5;
				res_s6.min  <= min_s5;
				res_s6.hour <= hour_n;
				res_s6.day  <= q_days[DAY_W-1:0];
				res_s6.ctrl <= {side_s5.carry | ovf, 1'b0, 5'b0, q_days[DAY_W-1]};
			end
		end
	end

	assign res_valid = v_s6;
	assign res       = res_s6;

endmodule

`default_nettype wire

/* design/mbc3_rtc_advance_top.sv */
// Throughput: one item per cycle while rsp is not stalled; six register stages,
// each loads when empty or when the stage after it moves, so a stall on rsp
// loses and repeats nothing. No unit is shared between items, so only stalls
// on rsp hold back the rate.
// Reset: arst_n clears all valid bits at once; the block is ready right after.
`timescale 1ns / 1ps
`default_nettype none

module mbc3_rtc_advance_top import rtca_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rtca_in_if.sink   req,
	rtca_out_if.source rsp
);

	logic              t_valid;
	logic              t_ready;
	logic [TIME_W-1:0] t_sum;
	rtca_side_t        t_side;
	rtca_res_t         res;

	rtca_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.t_valid (t_valid),
		.t_ready (t_ready),
		.t_sum   (t_sum),
		.t_side  (t_side)
	);

	rtca_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.t_valid   (t_valid),
		.t_ready   (t_ready),
		.t_sum     (t_sum),
		.t_side    (t_side),
		.res_valid (rsp.valid),
		.res_ready (rsp.ready),
		.res       (res)
	);

	// Drive the result channel from the last stage.
	assign rsp.sec_out  = res.sec;
	assign rsp.min_out  = res.min;
	assign rsp.hour_out = res.hour;
	assign rsp.day_out  = res.day;
	assign rsp.ctrl_out = res.ctrl;

endmodule

`default_nettype wire

/* design/rtca_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module rtca_checker (
	input wire logic   clk,
	input wire logic   arst_n,
	rtca_out_if.source rsp
);

	// A result that is not taken stays on the port unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.sec_out)
			&& $stable(rsp.min_out) && $stable(rsp.hour_out)
			&& $stable(rsp.day_out) && $stable(rsp.ctrl_out))
		else $error("result changed while stalled");

	// The split always yields fields in their clock range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.sec_out <= 6'd59 && rsp.min_out <= 6'd59
			&& rsp.hour_out <= 5'd23)
		else $error("clock field out of range");

	// Bit 0 of the control byte mirrors day bit 8; bits 5 to 1 stay clear.
	a_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.ctrl_out[0] == rsp.day_out[8] && rsp.ctrl_out[5:1] == 5'd0)
		else $error("control byte malformed");

	// Nothing comes out in the cycle after reset is released.
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp.valid)
		else $error("result present after reset");

endmodule

bind mbc3_rtc_advance_top rtca_checker u_rtca_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.rsp    (rsp)
);

`default_nettype wire

/* tb/sv/mbc3_rtc_advance_top_test.sv */
`timescale 1ns / 1ps

module mbc3_rtc_advance_top_test;
	import rtca_pkg::*;

	// Clock arithmetic constants of the predictor.
	localparam int unsigned MINS_PER_HOUR = 60;
	localparam int unsigned HOURS_PER_DAY = 24;
	localparam int unsigned DAY_LIMIT     = 2 ** DAY_W - 1;

	// Run control.
	localparam int PIPE_LATENCY = 6;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 950;
	localparam int CHUNKS       = 8;

	// One request item as the driver holds it.
	typedef struct packed {
		logic [SEC_W-1:0]  sec;
		logic [SEC_W-1:0]  min;
		logic [HOUR_W-1:0] hour;
		logic [DAY_W-1:0]  day;
		logic [CTRL_W-1:0] ctrl;
		logic [EL_W-1:0]   elapsed;
	} clock_req_t;

	logic clk;
	logic arst_n;

	rtca_in_if  req ();
	rtca_out_if rsp ();

	mbc3_rtc_advance_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	clock_req_t pending_reqs[$];
	rtca_res_t  expected_clocks[$];

	int  send_idle_pct;
	int  rsp_stall_pct;
	int  queued_reqs;
	int  accepted_reqs;
	int  mismatch_count;
	int  quiet_cycles;
	logic req_fire;

	// Free-running clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Advances the clamped clock by the elapsed seconds unless it is halted.
	function automatic rtca_res_t advance_clock(input clock_req_t r);
		longint unsigned secs_total;
		longint unsigned mins_total;
		longint unsigned hours_total;
		longint unsigned days_total;
		logic [SEC_W-1:0]  s;
		logic [SEC_W-1:0]  m;
		logic [HOUR_W-1:0] h;
		logic [DAY_W-1:0]  d;
		logic carry;
		logic halt;
		rtca_res_t res;
		s = (r.sec > SEC_MAX) ? SEC_MAX : r.sec;
		m = (r.min > MIN_MAX) ? MIN_MAX : r.min;
		h = (r.hour > HOUR_MAX) ? HOUR_MAX : r.hour;
		d = r.day;
		carry = r.ctrl[CTRL_CARRY_BIT];
		halt  = r.ctrl[CTRL_HALT_BIT];
		if (!halt) begin
			secs_total = 64'(s) + 64'(m) * SEC_PER_MIN + 64'(h) * SEC_PER_HOUR
				+ 64'(d) * SEC_PER_DAY + 64'(r.elapsed);
			s = SEC_W'(secs_total % SEC_PER_MIN);
			mins_total = secs_total / SEC_PER_MIN;
			m = SEC_W'(mins_total % MINS_PER_HOUR);
			hours_total = mins_total / MINS_PER_HOUR;
			h = HOUR_W'(hours_total % HOURS_PER_DAY);
			days_total = hours_total / HOURS_PER_DAY;
			// The carry bit is sticky: a wrap sets it, nothing clears it.
			if (days_total > DAY_LIMIT) begin
				carry = 1'b1;
			end
			d = DAY_W'(days_total);
		end
		res.sec  = s;
		res.min  = m;
		res.hour = h;
		res.day  = d;
		res.ctrl = '0;
		res.ctrl[CTRL_CARRY_BIT] = carry;
		res.ctrl[CTRL_HALT_BIT]  = halt;
		res.ctrl[0] = d[DAY_W-1];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic queue_req(input int s, input int m, input int h, input int d,
		input int c, input logic [EL_W-1:0] e);
		clock_req_t r;
		r.sec     = SEC_W'(s);
		r.min     = SEC_W'(m);
		r.hour    = HOUR_W'(h);
		r.day     = DAY_W'(d);
		r.ctrl    = CTRL_W'(c);
		r.elapsed = e;
		pending_reqs.push_back(r);
		queued_reqs++;
	endtask

	// Driver: a presented item stays until it is taken, then the next one may follow.
	always @(negedge clk) begin : drive_req
		clock_req_t nxt;
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req_fire) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_reqs.pop_front();
				req.valid   <= 1'b1;
				req.sec_in  <= nxt.sec;
				req.min_in  <= nxt.min;
				req.hour_in <= nxt.hour;
				req.day_in  <= nxt.day;
				req.ctrl_in <= nxt.ctrl;
				req.elapsed <= nxt.elapsed;
			end else begin
				req.valid   <= 1'b0;
				req.sec_in  <= SEC_W'($urandom);
				req.min_in  <= SEC_W'($urandom);
				req.hour_in <= HOUR_W'($urandom);
				req.day_in  <= DAY_W'($urandom);
				req.ctrl_in <= CTRL_W'($urandom);
				req.elapsed <= $urandom;
			end
		end
	end

	// Result backpressure.
	always @(negedge clk) begin
		rsp.ready <= arst_n && ($urandom_range(99) >= rsp_stall_pct);
	end

	// Monitor: predicts on each accepted request and checks each accepted result.
	always @(posedge clk or negedge arst_n) begin : watch
		clock_req_t seen;
		rtca_res_t want;
		if (!arst_n) begin
			req_fire      <= 1'b0;
			accepted_reqs <= 0;
		end else begin
			req_fire <= req.valid && req.ready;
			if (rsp.valid && rsp.ready) begin
				if (expected_clocks.size() == 0) begin
					report_mismatch("result with no request outstanding", 0, 0);
				end else begin
					want = expected_clocks.pop_front();
					if (rsp.sec_out != want.sec)
						report_mismatch("sec_out", rsp.sec_out, want.sec);
					if (rsp.min_out != want.min)
						report_mismatch("min_out", rsp.min_out, want.min);
					if (rsp.hour_out != want.hour)
						report_mismatch("hour_out", rsp.hour_out, want.hour);
					if (rsp.day_out != want.day)
						report_mismatch("day_out", rsp.day_out, want.day);
					if (rsp.ctrl_out != want.ctrl)
						report_mismatch("ctrl_out", rsp.ctrl_out, want.ctrl);
				end
			end
			if (req.valid && req.ready) begin
				seen.sec     = req.sec_in;
				seen.min     = req.min_in;
				seen.hour    = req.hour_in;
				seen.day     = req.day_in;
				seen.ctrl    = req.ctrl_in;
				seen.elapsed = req.elapsed;
				expected_clocks.push_back(advance_clock(seen));
				accepted_reqs <= accepted_reqs + 1;
			end
		end
	end

	// Watchdog: ends the run when no item moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [EL_W-1:0] el;
		logic [CTRL_W-1:0] c;
		int per_chunk;
		clk            = 1'b0;
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.sec_in     = '0;
		req.min_in     = '0;
		req.hour_in    = '0;
		req.day_in     = '0;
		req.ctrl_in    = '0;
		req.elapsed    = '0;
		rsp.ready      = 1'b0;
		send_idle_pct  = 0;
		rsp_stall_pct  = 0;
		queued_reqs    = 0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed items: field extremes, clamping, halt, control bits and day wrap.
		queue_req(0, 0, 0, 0, 8'h00, 32'd0);
		queue_req(63, 63, 31, 511, 8'hFF, 32'hFFFF_FFFF);
		queue_req(63, 63, 31, 511, 8'hBF, 32'hFFFF_FFFF);
		queue_req(59, 59, 23, 511, 8'h00, 32'd1);
		queue_req(59, 59, 23, 511, 8'h00, 32'd0);
		queue_req(0, 0, 0, 0, 8'h00, 32'hFFFF_FFFF);
		queue_req(60, 60, 24, 255, 8'h00, 32'd1);
		queue_req(5, 6, 7, 256, 8'h40, 32'd12345);
		queue_req(61, 62, 30, 0, 8'hC1, 32'd99999);
		queue_req(0, 0, 0, 0, 8'h01, 32'd0);
		queue_req(0, 0, 0, 100, 8'h3E, 32'd86400);
		queue_req(0, 0, 0, 10, 8'h80, 32'd3600);
		queue_req(61, 62, 30, 0, 8'h00, 32'd59);
		queue_req(0, 0, 0, 0, 8'h00, 32'd44236800);
		queue_req(0, 0, 0, 0, 8'h00, 32'd44236799);
		queue_req(1, 2, 3, 4, 8'h42, 32'd0);
		queue_req(32, 16, 8, 128, 8'h00, 32'h8000_0000);
		queue_req(31, 47, 15, 383, 8'h81, 32'h7FFF_FFFF);
		queue_req(59, 59, 23, 255, 8'h01, 32'd1);
		queue_req(40, 30, 20, 300, 8'hC0, 32'd0);
		while (accepted_reqs != queued_reqs) @(posedge clk);

		// Random items in chunks that rotate through the idling phases.
		per_chunk = RANDOM_ITEMS / CHUNKS;
		for (int chunk = 0; chunk < CHUNKS; chunk++) begin
			case (chunk % 4)
				0: begin
					send_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 68;
					rsp_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					rsp_stall_pct = 68;
				end
				default: begin
					send_idle_pct = 30;
					rsp_stall_pct = 30;
				end
			endcase
			// Halfway, the sender holds back until the pipeline has drained.
			if (chunk == CHUNKS / 2) begin
				while (expected_clocks.size() != 0) @(posedge clk);
			end
			for (int i = 0; i < per_chunk; i++) begin
				case ($urandom_range(3))
					0: el = $urandom;
					1: el = $urandom_range(100000);
					2: el = $urandom_range(600) * SEC_PER_DAY + $urandom_range(86399);
					default: el = 32'hFFFF_FFFF - $urandom_range(1000);
				endcase
				c = CTRL_W'($urandom);
				if ($urandom_range(3) != 0) begin
					c[CTRL_HALT_BIT] = 1'b0;
				end
				queue_req(($urandom_range(3) == 0) ? $urandom_range(63, 56) : $urandom_range(63),
					($urandom_range(3) == 0) ? $urandom_range(63, 56) : $urandom_range(63),
					($urandom_range(3) == 0) ? $urandom_range(31, 20) : $urandom_range(31),
					($urandom_range(3) == 0) ? $urandom_range(511, 480) : $urandom_range(511),
					c, el);
			end
			while (accepted_reqs != queued_reqs) @(posedge clk);
		end

		// Drain, then keep watching for any stray result before the verdict.
		while (expected_clocks.size() != 0) @(posedge clk);
		repeat (3 * PIPE_LATENCY) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
